### rtl/core/rfd_pkg.sv
package rfd_pkg;

  // Frame buffer size in bytes; a length byte must be below this value.
  localparam int BUF_BYTES = 20;
  localparam int LEN_W     = $clog2(BUF_BYTES);

  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [15:0] IDLE_LIMIT_RST = 16'hFFFF;

  localparam logic [1:0] MODE_BYTE    = 2'd0;
  localparam logic [1:0] MODE_IDLE    = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  localparam logic REG_IDLE_LIMIT = 1'b0;

  typedef enum logic [2:0] {
    ST_TAKEN    = 3'd0,
    ST_GOOD     = 3'd1,
    ST_DROP     = 3'd2,
    ST_CRCBAD   = 3'd3,
    ST_TIMEOUT  = 3'd4,
    ST_RELEASED = 3'd5,
    ST_NOTHING  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_LOAD
  } fsm_state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic read;
    logic load;
  } rfd_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic run;
    logic last;
  } rfd_sts_t;

  // CRC-16, polynomial 0x1021, MSB first, one byte.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/rfd_ctrl.sv
module rfd_ctrl
  import rfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  rfd_sts_t sts,
  output rfd_cmd_t cmd
);

  fsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.slot_free) state_nxt = sts.run ? S_READ : S_IDLE;
      end
      S_READ: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (sts.slot_free) state_nxt = sts.last ? S_IDLE : S_READ;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      S_EXEC: begin
        cmd.exec = sts.slot_free;
      end
      S_READ: begin
        cmd.read = 1'b1;
      end
      S_LOAD: begin
        cmd.load = sts.slot_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

### rtl/core/rfd_dp.sv
module rfd_dp
  import rfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  rfd_cmd_t    cmd,
  output rfd_sts_t    sts,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_byte,
  input  logic        cfg_wr,
  input  logic        cfg_idx,
  input  logic [15:0] cfg_wdata,
  output logic [31:0] cfg_rdata,
  output logic        out_valid,
  input  logic        out_ready,
  output status_t     out_status,
  output logic [7:0]  out_pbyte,
  output logic [4:0]  out_plen,
  output logic        out_last
);

  logic [7:0] mem [BUF_BYTES];

  logic [1:0]       mode_r;
  logic [7:0]       byte_r;
  logic [15:0]      limit_r;
  logic             receiving_r, receiving_nxt;
  logic             held_r, held_nxt;
  logic [LEN_W-1:0] frame_len_r, frame_len_nxt;
  logic [LEN_W-1:0] seen_r, seen_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [15:0]      idle_r, idle_nxt;
  logic [7:0]       prev_r;
  logic [LEN_W-1:0] k_r;
  logic [7:0]       rd_r;

  logic             out_valid_r;
  status_t          out_status_r;
  logic [7:0]       out_pbyte_r;
  logic [4:0]       out_plen_r;
  logic             out_last_r;

  status_t          res_status;
  logic [LEN_W-1:0] res_plen;
  logic             res_run;
  logic [LEN_W-1:0] plen;
  logic [LEN_W-1:0] seen_inc;
  logic [LEN_W-1:0] byte_len;
  logic             byte_fits;
  logic             do_write;

  function automatic logic [4:0] to_plen(input logic [LEN_W-1:0] v);
    logic [7:0] ext;
    ext = {{(8 - LEN_W){1'b0}}, v};
    return ext[4:0];
  endfunction

  assign plen      = frame_len_r - LEN_W'(2);
  assign seen_inc  = seen_r + LEN_W'(1);
  assign byte_len  = byte_r[LEN_W-1:0];
  assign byte_fits = (byte_r >= 8'd2) && (byte_r < 8'(BUF_BYTES));
  assign do_write  = cmd.exec && (mode_r == MODE_BYTE) && receiving_r;

  // One input item: new state and the single result, or the start of a payload run.
  always_comb begin
    receiving_nxt = receiving_r;
    held_nxt      = held_r;
    frame_len_nxt = frame_len_r;
    seen_nxt      = seen_r;
    crc_nxt       = crc_r;
    idle_nxt      = idle_r;
    res_status    = ST_NOTHING;
    res_plen      = '0;
    res_run       = 1'b0;
    case (mode_r)
      MODE_BYTE: begin
        if (!receiving_r) begin
          if (!byte_fits || held_r) begin
            res_status = ST_DROP;
          end else begin
            receiving_nxt = 1'b1;
            frame_len_nxt = byte_len;
            seen_nxt      = '0;
            crc_nxt       = '0;
            idle_nxt      = '0;
            res_status    = ST_TAKEN;
            res_plen      = byte_len - LEN_W'(2);
          end
        end else begin
          idle_nxt = '0;
          seen_nxt = seen_inc;
          res_plen = plen;
          if (seen_r < plen) crc_nxt = crc16_byte(crc_r, byte_r);
          if (seen_inc < frame_len_r) begin
            res_status = ST_TAKEN;
          end else begin
            receiving_nxt = 1'b0;
            // The last two bytes of the frame carry the CRC, high byte first.
            if ({prev_r, byte_r} != crc_r) begin
              res_status = ST_CRCBAD;
            end else begin
              held_nxt   = 1'b1;
              res_status = ST_GOOD;
              res_run    = (plen != '0);
            end
          end
        end
      end
      MODE_IDLE: begin
        if (receiving_r) begin
          res_plen = plen;
          if (idle_r >= limit_r) begin
            receiving_nxt = 1'b0;
            idle_nxt      = '0;
            res_status    = ST_TIMEOUT;
          end else begin
            idle_nxt   = idle_r + 16'd1;
            res_status = ST_TAKEN;
          end
        end
      end
      MODE_RELEASE: begin
        if (held_r) begin
          held_nxt   = 1'b0;
          res_status = ST_RELEASED;
        end
      end
      default: begin
        res_status = ST_NOTHING;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      byte_r <= in_byte;
    end
    if (do_write) begin
      mem[seen_r] <= byte_r;
      prev_r      <= byte_r;
    end
    if (cmd.read) rd_r <= mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= IDLE_LIMIT_RST;
      receiving_r <= 1'b0;
      held_r      <= 1'b0;
      frame_len_r <= '0;
      seen_r      <= '0;
      crc_r       <= '0;
      idle_r      <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && (cfg_idx == REG_IDLE_LIMIT)) limit_r <= cfg_wdata;
      out_valid_r <= (out_valid_r && !out_ready) || (cmd.exec && !res_run) || cmd.load;
      if (cmd.exec) begin
        receiving_r <= receiving_nxt;
        held_r      <= held_nxt;
        frame_len_r <= frame_len_nxt;
        seen_r      <= seen_nxt;
        crc_r       <= crc_nxt;
        idle_r      <= idle_nxt;
        k_r         <= '0;
      end
      if (cmd.load) begin
        k_r         <= k_r + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && !res_run) begin
      out_status_r <= res_status;
      out_pbyte_r  <= 8'd0;
      out_plen_r   <= to_plen(res_plen);
      out_last_r   <= 1'b1;
    end else if (cmd.load) begin
      out_status_r <= ST_GOOD;
      out_pbyte_r  <= rd_r;
      out_plen_r   <= to_plen(plen);
      out_last_r   <= sts.last;
    end
  end

  assign sts.slot_free = !out_valid_r || out_ready;
  assign sts.run       = res_run;
  assign sts.last      = (k_r + LEN_W'(1)) == plen;

  assign cfg_rdata  = (cfg_idx == REG_IDLE_LIMIT) ? {16'd0, limit_r} : 32'd0;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_pbyte  = out_pbyte_r;
  assign out_plen   = out_plen_r;
  assign out_last   = out_last_r;

endmodule

### rtl/core/radio_frame_deframer_crc16.sv
// Length-prefixed radio frame receiver with CRC-16 (poly 0x1021, init 0) check.
// Each input transaction carries a received byte, an idle tick or a release
// request (tuser), and produces one result, except the last byte of a good
// frame, which produces one result per payload byte, the final one with tlast.
// A single-result transaction is captured in the accepting cycle; in S_EXEC,
// once the output register is free, it is evaluated, the frame state is updated
// and the output register loaded. A good frame's payload then streams out of
// the frame buffer one byte at a time (buffer read, then output load), up to 17
// bytes. The input is accepted again as soon as the last result is in the output
// register; output backpressure stalls both the evaluation and the output loads.
// The idle tick limit register sits at address 0.
module radio_frame_deframer_crc16
  import rfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] payload_byte, [12:8] payload_len, [15:13] zero
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic        out_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rfd_cmd_t   cmd;
  rfd_sts_t   sts;
  status_t    out_status;
  logic [7:0] out_pbyte;
  logic [4:0] out_plen;

  assign pready = 1'b1;

  rfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rfd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_mode    (in_tuser),
    .in_byte    (in_tdata),
    .cfg_wr     (psel && penable && pwrite && pready),
    .cfg_idx    (paddr[2]),
    .cfg_wdata  (pwdata[15:0]),
    .cfg_rdata  (prdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_status),
    .out_pbyte  (out_pbyte),
    .out_plen   (out_plen),
    .out_last   (out_tlast)
  );

  assign out_tdata = {3'b000, out_plen, out_pbyte};
  assign out_tuser = out_status;

endmodule

### rtl/core/rfd_chk.sv
module rfd_chk
  import rfd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // The output register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // An accepted item blocks the input in the following cycle, so it is evaluated before the next is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  // Only good-packet results carry payload bytes.
  a_pbyte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_GOOD) |-> (out_tdata[7:0] == 8'd0) && out_tlast)
    else $error("payload byte on a non-packet result");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind radio_frame_deframer_crc16 rfd_chk u_rfd_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import rfd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 64;
  localparam logic [2:0] LIMIT_ADDR = 3'(REG_IDLE_LIMIT) * 3'd4;

  typedef struct {
    status_t    st;
    logic [7:0] pbyte;
    logic [4:0] plen;
    logic       lst;
  } deframe_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic [1:0]  in_tuser;   // [1:0] mode
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [7:0] payload_byte, [12:8] payload_len, [15:13] zero
  logic [2:0]  out_tuser;  // [2:0] status
  logic        out_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Deframer state as the block should hold it.
  logic        rx_active;
  logic [4:0]  rx_len;
  logic [4:0]  rx_count;
  logic [15:0] rx_crc;
  logic [7:0]  rx_buf [BUF_BYTES];
  logic        pkt_held;
  logic [15:0] idle_count;
  logic [15:0] idle_limit;

  deframe_result_t deframe_results[$];

  int  fail_count;
  int  cycle_count;
  int  items_accepted;
  int  results_checked;
  int  good_runs, crc_fails, timeouts, drops;
  bit  calm;
  int  rx_hold_cycles;

  radio_frame_deframer_crc16 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, deframe_results.size());
      $display("** radio_frame_deframer_crc16: FAILED **");
      $finish;
    end
  end

  function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] d);
    logic [15:0] r;
    r = c ^ {d, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  function automatic void expect_result(status_t st, logic [7:0] pb, logic [4:0] pl,
                                        logic lst);
    deframe_result_t e;
    e.st = st;
    e.pbyte = pb;
    e.plen = pl;
    e.lst = lst;
    deframe_results.push_back(e);
  endfunction

  function automatic void deframer_reset();
    rx_active = 1'b0;
    rx_len = '0;
    rx_count = '0;
    rx_crc = '0;
    pkt_held = 1'b0;
    idle_count = '0;
    idle_limit = IDLE_LIMIT_RST;
    for (int i = 0; i < BUF_BYTES; i++) rx_buf[i] = '0;
  endfunction

  function automatic void deframe_item(logic [1:0] mode, logic [7:0] b);
    logic [4:0]  plen;
    logic [4:0]  idx;
    logic [15:0] rx_field;
    plen = rx_len - 5'd2;
    if (mode == MODE_BYTE) begin
      if (!rx_active) begin
        if (b < 2 || b >= BUF_BYTES || pkt_held) begin
          drops++;
          expect_result(ST_DROP, 8'h00, 5'd0, 1'b1);
        end else begin
          rx_active = 1'b1;
          rx_len = b[4:0];
          rx_count = '0;
          rx_crc = '0;
          idle_count = '0;
          expect_result(ST_TAKEN, 8'h00, b[4:0] - 5'd2, 1'b1);
        end
      end else begin
        idx = rx_count;
        idle_count = '0;
        if (idx < BUF_BYTES) rx_buf[idx] = b;
        if (idx < plen) rx_crc = crc_next(rx_crc, b);
        rx_count = idx + 5'd1;
        if (int'(idx) + 1 < int'(rx_len)) begin
          expect_result(ST_TAKEN, 8'h00, plen, 1'b1);
        end else begin
          rx_active = 1'b0;
          // The trailer sits right after the payload, high byte first.
          rx_field = {rx_buf[plen], rx_buf[plen + 5'd1]};
          if (rx_field != rx_crc) begin
            crc_fails++;
            expect_result(ST_CRCBAD, 8'h00, plen, 1'b1);
          end else begin
            pkt_held = 1'b1;
            good_runs++;
            if (plen == 0) begin
              expect_result(ST_GOOD, 8'h00, 5'd0, 1'b1);
            end else begin
              for (int k = 0; k < plen; k++) begin
                expect_result(ST_GOOD, rx_buf[k], plen, k + 1 == plen);
              end
            end
          end
        end
      end
    end else if (mode == MODE_IDLE) begin
      if (!rx_active) begin
        expect_result(ST_NOTHING, 8'h00, 5'd0, 1'b1);
      end else if (idle_count >= idle_limit) begin
        rx_active = 1'b0;
        idle_count = '0;
        timeouts++;
        expect_result(ST_TIMEOUT, 8'h00, plen, 1'b1);
      end else begin
        idle_count = idle_count + 16'd1;
        expect_result(ST_TAKEN, 8'h00, plen, 1'b1);
      end
    end else if (mode == MODE_RELEASE && pkt_held) begin
      pkt_held = 1'b0;
      expect_result(ST_RELEASED, 8'h00, 5'd0, 1'b1);
    end else begin
      expect_result(ST_NOTHING, 8'h00, 5'd0, 1'b1);
    end
  endfunction

  always @(posedge clk) begin
    deframe_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (deframe_results.size() == 0) begin
        $error("unexpected result: status %0d, data %h, last %b", out_tuser, out_tdata,
               out_tlast);
        fail_count++;
      end else begin
        want = deframe_results.pop_front();
        results_checked++;
        if (out_tuser !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, out_tuser);
          fail_count++;
        end
        if (out_tdata[7:0] !== want.pbyte) begin
          $error("payload_byte: expected %0d, got %0d", want.pbyte, out_tdata[7:0]);
          fail_count++;
        end
        if (out_tdata[12:8] !== want.plen) begin
          $error("payload_len: expected %0d, got %0d", want.plen, out_tdata[12:8]);
          fail_count++;
        end
        if (out_tlast !== want.lst) begin
          $error("last: expected %0d, got %0d", want.lst, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Result side: random stalls, calm stretches and counted hold-offs.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_tready <= 1'b0;
        rx_hold_cycles--;
      end else if (calm) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 13);
      end
    end
  end

  // Leaves tvalid high after the transaction so back-to-back items need no bubble.
  task automatic send_item(input logic [1:0] mode, input logic [7:0] b);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 13) gap = $urandom_range(1, 4);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    deframe_item(mode, b);
    items_accepted++;
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (deframe_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_idle_limit(input logic [15:0] v);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= LIMIT_ADDR;
    pwdata <= {16'h0000, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    idle_limit = v;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    psel <= 1'b1;
    paddr <= LIMIT_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {16'h0000, v}) begin
      $error("idle_tick_limit: expected %0d, got %0d", v, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Sends a length byte, payload and CRC trailer, with optional idle ticks between
  // bytes; a corrupted trailer has one bit flipped.
  task automatic send_frame(input int flen, input bit corrupt, input bit with_idles);
    logic [7:0]  body[$];
    logic [7:0]  b;
    logic [15:0] c;
    int          span;
    c = '0;
    for (int k = 0; k < flen - 2; k++) begin
      b = 8'($urandom);
      body.push_back(b);
      c = crc_next(c, b);
    end
    if (corrupt) c = c ^ (16'h0001 << $urandom_range(0, 15));
    body.push_back(c[15:8]);
    body.push_back(c[7:0]);
    span = (idle_limit < 8) ? int'(idle_limit) + 1 : 3;
    send_item(MODE_BYTE, 8'(flen));
    foreach (body[k]) begin
      if (with_idles && $urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(0, span)) send_item(MODE_IDLE, 8'($urandom));
      end
      send_item(MODE_BYTE, body[k]);
    end
  endtask

  task automatic test_register_access();
    write_idle_limit(16'd1);
    write_idle_limit(16'hA5C3);
    write_idle_limit(16'h5A3C);
    write_idle_limit(16'hFFFF);
  endtask

  task automatic test_directed_frames();
    send_item(MODE_BYTE, 8'd0);
    send_item(MODE_BYTE, 8'd1);
    send_item(MODE_BYTE, 8'(BUF_BYTES));
    send_item(MODE_BYTE, 8'hFF);
    send_item(MODE_IDLE, 8'hFF);
    send_item(MODE_RELEASE, 8'h00);
    // Empty payload: the trailer is the CRC of nothing, which is zero.
    send_item(MODE_BYTE, 8'd2);
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_BYTE, 8'd3);
    send_item(MODE_RELEASE, 8'hFF);
    send_item(MODE_BYTE, 8'd3);
    send_item(MODE_BYTE, 8'hFF);
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_BYTE, 8'h00);
    send_frame(3, 1'b0, 1'b0);
    send_item(MODE_RELEASE, 8'h00);
    // A release while a frame is coming in has nothing to free.
    send_item(MODE_BYTE, 8'd2);
    send_item(MODE_RELEASE, 8'h00);
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_RELEASE, 8'h00);
    wait_results_done();
  endtask

  task automatic test_idle_timeout();
    write_idle_limit(16'd1);
    send_item(MODE_BYTE, 8'd4);
    send_item(MODE_IDLE, 8'h00);
    send_item(MODE_IDLE, 8'h00);
    send_item(MODE_IDLE, 8'h00);
    wait_results_done();
    write_idle_limit(16'd3);
    send_item(MODE_BYTE, 8'd5);
    repeat (3) send_item(MODE_IDLE, 8'h00);
    send_item(MODE_BYTE, 8'h5A);
    repeat (4) send_item(MODE_IDLE, 8'h00);
    wait_results_done();
    write_idle_limit(16'hFFFF);
    send_item(MODE_BYTE, 8'd2);
    repeat (6) send_item(MODE_IDLE, 8'h00);
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_RELEASE, 8'h00);
    wait_results_done();
  endtask

  task automatic test_output_backpressure();
    rx_hold_cycles = 150;
    send_frame(BUF_BYTES - 1, 1'b0, 1'b0);
    send_item(MODE_RELEASE, 8'h00);
    repeat (6) send_item(MODE_IDLE, 8'($urandom));
    send_frame(BUF_BYTES - 1, 1'b0, 1'b0);
    send_item(MODE_RELEASE, 8'h00);
    wait_results_done();
  endtask

  task automatic test_random_traffic();
    logic [15:0] limits[4];
    int          r;
    int          stop_at;
    limits[0] = 16'd1;
    limits[1] = 16'(($urandom_range(2, 6)));
    limits[2] = 16'hFFFF;
    limits[3] = 16'(($urandom_range(1, 65535)));
    for (int phase = 0; phase < 4; phase++) begin
      wait_results_done();
      write_idle_limit(limits[phase]);
      calm = (phase == 2);
      stop_at = items_accepted + RANDOM_ITEMS / 4;
      while (items_accepted < stop_at) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          send_frame($urandom_range(2, BUF_BYTES - 1), $urandom_range(0, 9) == 0, 1'b1);
          if ($urandom_range(0, 9) < 8) send_item(MODE_RELEASE, 8'($urandom));
        end else if (r < 70) begin
          send_item(MODE_IDLE, 8'($urandom));
        end else if (r < 80) begin
          send_item(MODE_RELEASE, 8'($urandom));
        end else if (r < 92) begin
          send_item(MODE_BYTE, 8'($urandom));
        end else begin
          send_item(2'($urandom_range(0, 2)), 8'($urandom));
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    rx_hold_cycles = 0;
    deframer_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_access();
    test_directed_frames();
    test_idle_timeout();
    test_output_backpressure();
    test_random_traffic();

    wait_results_done();
    repeat (40) @(posedge clk);
    $display("Sent %0d input transactions and checked %0d results.", items_accepted,
             results_checked);
    $display("Seen: %0d good payload runs, %0d CRC failures, %0d timeouts, %0d drops.",
             good_runs, crc_fails, timeouts, drops);
    if (fail_count == 0) begin
      $display("** radio_frame_deframer_crc16: PASSED **");
    end else begin
      $display("** radio_frame_deframer_crc16: FAILED **");
    end
    $finish;
  end

endmodule
